// ----- rtl/mbe_pkg.sv -----
// Shared types, constants and codes for the escape-time evaluator.
package mbe_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS_DEF = 28;
    localparam int OFF_FRAC      = 28;
    localparam int ZOOM_W        = 24;
    localparam int DIM_W         = 13;
    localparam int ITER_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int DIV_W         = ZOOM_W + DIM_W;
    localparam int NUM_W         = COORD_BITS + 2;
    localparam int NUM_SHIFT     = 11;

    localparam logic [ZOOM_W-1:0]            ZOOM_RST   = 24'd65536;
    localparam logic signed [CFG_DATA_W-1:0] OFFR_RST   = -32'sd134217728;
    localparam logic signed [CFG_DATA_W-1:0] OFFI_RST   = 32'sd0;
    localparam logic [DIM_W-1:0]             WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0]             HEIGHT_RST = 13'd1024;
    localparam logic [ITER_W-1:0]            LIMIT_RST  = 16'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM   = 3'd0,
        REG_OFFR   = 3'd1,
        REG_OFFI   = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4,
        REG_LIMIT  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DLOAD,
        ST_DIV,
        ST_MAP,
        ST_START,
        ST_MUL1,
        ST_MUL2,
        ST_UPD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [ITER_W-1:0]     iteration_count;
        logic                  inside_set;
    } out_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_load;
        logic div_step;
        logic map_done;
        logic update;
        logic first;
        logic check;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic escape;
        logic last;
        logic limit_zero;
    } dp_status_t;

endpackage

// ----- rtl/mbe_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
module mbe_mul #(
    parameter int W = mbe_pkg::FRAC_BITS_DEF + 4
) (
    input  logic           aclk,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);
    localparam int H = (W + 1) / 2;
    localparam int L = W - H;

    logic [H-1:0]     a_lo, b_lo;
    logic [L-1:0]     a_hi, b_hi;
    logic [2*H-1:0]   pll_reg;
    logic [H+L-1:0]   plh_reg, phl_reg;
    logic [2*L-1:0]   phh_reg;
    logic [2*W-1:0]   p_reg, p_next;

    assign a_lo = a[H-1:0];
    assign a_hi = a[W-1:H];
    assign b_lo = b[H-1:0];
    assign b_hi = b[W-1:H];

    always_comb begin
        p_next = (2*W)'(pll_reg)
               + ((2*W)'(plh_reg) << H)
               + ((2*W)'(phl_reg) << H)
               + ((2*W)'(phh_reg) << (2*H));
    end

    always_ff @(posedge aclk) begin
        pll_reg <= (2*H)'(a_lo) * (2*H)'(b_lo);
        plh_reg <= (H+L)'(a_lo) * (H+L)'(b_hi);
        phl_reg <= (H+L)'(a_hi) * (H+L)'(b_lo);
        phh_reg <= (2*L)'(a_hi) * (2*L)'(b_hi);
        p_reg   <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/mbe_div.sv -----
// Restoring divider, one quotient bit per step, with saturation to the coordinate limit.
module mbe_div #(
    parameter int QB = mbe_pkg::FRAC_BITS_DEF + 5
) (
    input  logic                      aclk,
    input  logic                      load,
    input  logic                      step,
    input  logic [mbe_pkg::NUM_W-1:0] num,
    input  logic [mbe_pkg::DIV_W-1:0] den,
    output logic [QB-1:0]             quo
);
    import mbe_pkg::*;

    localparam logic [QB-1:0] CAP = {1'b1, {(QB-1){1'b0}}};

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [QB-1:0]    quo_reg, quo_next;
    logic             ovf_reg, ovf_next;
    logic             run_reg, run_next;
    logic [DIV_W-1:0] num_sh;
    logic [DIV_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        num_sh   = DIV_W'(num) << NUM_SHIFT;
        rem_sh   = {rem_reg, 1'b0};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        ovf_next = ovf_reg;
        run_next = run_reg;
        if (load) begin
            den_next = den;
            rem_next = num_sh;
            quo_next = '0;
            if (den == '0) begin
                ovf_next = (num != '0);
                run_next = 1'b0;
            end else if (num_sh >= den) begin
                ovf_next = 1'b1;
                run_next = 1'b0;
            end else begin
                ovf_next = 1'b0;
                run_next = 1'b1;
            end
        end else if (step && run_reg) begin
            rem_next = ge ? DIV_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[QB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        run_reg <= run_next;
    end

    assign quo = (ovf_reg || quo_reg > CAP) ? CAP : quo_reg;

endmodule

// ----- rtl/mbe_datapath.sv -----
// Datapath: configuration registers, coordinate mapping and the z = z^2 + c loop.
module mbe_datapath #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  mbe_pkg::in_t                   s_data,
    input  mbe_pkg::ctrl_cmd_t             cmd,
    output mbe_pkg::dp_status_t            st,
    output mbe_pkg::out_t                  m_data
);
    import mbe_pkg::*;

    localparam int QW      = FRAC_BITS + 4;
    localparam int PW      = 2 * QW;
    localparam int SW      = QW + 5;
    localparam int QB      = FRAC_BITS + 5;
    localparam int OFF_W   = 64;
    localparam int OFF_LSH = (FRAC_BITS >= OFF_FRAC) ? FRAC_BITS - OFF_FRAC : 0;
    localparam int OFF_RSH = (FRAC_BITS < OFF_FRAC) ? OFF_FRAC - FRAC_BITS : 0;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-QW+1){1'b0}}, {(QW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-QW+1){1'b1}}, {(QW-1){1'b0}}};
    localparam logic [PW:0]          THR    = (PW+1)'(1) << (2*FRAC_BITS + 2);
    localparam logic [QW+3:0]        CAPM   = (QW+4)'(1) << QW;

    function automatic logic signed [QW-1:0] sat_q(input logic signed [SW-1:0] v);
        if (v > SAT_HI) return SAT_HI[QW-1:0];
        if (v < SAT_LO) return SAT_LO[QW-1:0];
        return v[QW-1:0];
    endfunction

    // configuration
    logic [ZOOM_W-1:0]            zoom_reg;
    logic signed [CFG_DATA_W-1:0] offr_reg, offi_reg;
    logic [DIM_W-1:0]             width_reg, height_reg;
    logic [ITER_W-1:0]            limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg   <= ZOOM_RST;
            offr_reg   <= OFFR_RST;
            offi_reg   <= OFFI_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            limit_reg  <= LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ZOOM:   zoom_reg   <= cfg_data[ZOOM_W-1:0];
                REG_OFFR:   offr_reg   <= cfg_data;
                REG_OFFI:   offi_reg   <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel capture and mapping preparation
    logic [COORD_BITS-1:0]   px_reg, py_reg;
    logic [COORD_BITS-1:0]   half_x, half_y, magx, magy;
    logic signed [COORD_BITS:0] dx, dy;
    logic [NUM_W-1:0]        numx_reg, numx_next, numy_reg, numy_next;
    logic [DIV_W-1:0]        denx_reg, denx_next, deny_reg, deny_next;
    logic                    negx_reg, negy_reg;
    logic signed [OFF_W-1:0] offw_r, offw_i;
    logic signed [QW-1:0]    offqr_reg, offqi_reg;

    always_comb begin
        half_x    = COORD_BITS'(width_reg >> 1);
        half_y    = COORD_BITS'(height_reg >> 1);
        dx        = $signed({1'b0, px_reg}) - $signed({1'b0, half_x});
        dy        = $signed({1'b0, py_reg}) - $signed({1'b0, half_y});
        magx      = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        magy      = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        numx_next = NUM_W'(magx) + NUM_W'({magx, 1'b0});
        numy_next = NUM_W'({magy, 1'b0});
        denx_next = DIV_W'(zoom_reg) * DIV_W'(width_reg);
        deny_next = DIV_W'(zoom_reg) * DIV_W'(height_reg);
        offw_r    = OFF_W'(offr_reg);
        offw_i    = OFF_W'(offi_reg);
        offw_r    = (offw_r <<< OFF_LSH) >>> OFF_RSH;
        offw_i    = (offw_i <<< OFF_LSH) >>> OFF_RSH;
    end

    // dividers, one per axis
    logic [QB-1:0] qm_x, qm_y;

    mbe_div #(.QB(QB)) u_div_x (
        .aclk (aclk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (numx_reg),
        .den  (denx_reg),
        .quo  (qm_x)
    );

    mbe_div #(.QB(QB)) u_div_y (
        .aclk (aclk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (numy_reg),
        .den  (deny_reg),
        .quo  (qm_y)
    );

    // iteration loop
    logic signed [QW-1:0] cre_reg, cim_reg, cre_next, cim_next;
    logic [QW-1:0]        re_mag_reg, im_mag_reg, re_mag_next, im_mag_next;
    logic                 re_neg_reg, im_neg_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [PW-1:0]        p_rr, p_ii, p_ri, sq_re, sq_im, cr;
    logic signed [SW-1:0] qx, qy, tre, tim, cx, nre_w, nim_w;
    logic signed [QW-1:0] nre, nim;
    logic [QW+3:0]        cm;
    logic [QW:0]          cm_cap;
    logic [PW:0]          ssum;

    mbe_mul #(.W(QW)) u_mul_rr (.aclk(aclk), .a(re_mag_reg), .b(re_mag_reg), .p(p_rr));
    mbe_mul #(.W(QW)) u_mul_ii (.aclk(aclk), .a(im_mag_reg), .b(im_mag_reg), .p(p_ii));
    mbe_mul #(.W(QW)) u_mul_ri (.aclk(aclk), .a(re_mag_reg), .b(im_mag_reg), .p(p_ri));

    always_comb begin
        qx = SW'(qm_x);
        qy = SW'(qm_y);
        if (negx_reg) qx = -qx;
        if (negy_reg) qy = -qy;
        cre_next = sat_q(qx + SW'(offqr_reg));
        cim_next = sat_q(qy + SW'(offqi_reg));

        sq_re  = cmd.first ? '0 : p_rr;
        sq_im  = cmd.first ? '0 : p_ii;
        cr     = cmd.first ? '0 : p_ri;
        tre    = SW'(sq_re >> FRAC_BITS);
        tim    = SW'(sq_im >> FRAC_BITS);
        cm     = (QW+4)'(cr >> FRAC_BITS);
        cm_cap = (cm > CAPM) ? CAPM[QW:0] : cm[QW:0];
        cx     = SW'({cm_cap, 1'b0});
        if (re_neg_reg ^ im_neg_reg) cx = -cx;
        nre_w  = tre - tim + SW'(cre_reg);
        nim_w  = cx + SW'(cim_reg);
        nre    = sat_q(nre_w);
        nim    = sat_q(nim_w);
        re_mag_next = nre[QW-1] ? QW'(-nre) : QW'(nre);
        im_mag_next = nim[QW-1] ? QW'(-nim) : QW'(nim);

        ssum = (PW+1)'(p_rr) + (PW+1)'(p_ii);
    end

    assign st.escape     = ssum > THR;
    assign st.last       = ((ITER_W+1)'(iter_reg) + (ITER_W+1)'(1)) == (ITER_W+1)'(limit_reg);
    assign st.limit_zero = (limit_reg == '0);

    out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= s_data.pixel_x;
            py_reg <= s_data.pixel_y;
        end
        if (cmd.prep) begin
            numx_reg  <= numx_next;
            numy_reg  <= numy_next;
            denx_reg  <= denx_next;
            deny_reg  <= deny_next;
            negx_reg  <= dx[COORD_BITS];
            negy_reg  <= dy[COORD_BITS];
            offqr_reg <= offw_r[QW-1:0];
            offqi_reg <= offw_i[QW-1:0];
        end
        if (cmd.map_done) begin
            cre_reg  <= cre_next;
            cim_reg  <= cim_next;
            iter_reg <= '0;
        end
        if (cmd.update) begin
            re_mag_reg <= re_mag_next;
            im_mag_reg <= im_mag_next;
            re_neg_reg <= nre[QW-1];
            im_neg_reg <= nim[QW-1];
        end
        if (cmd.check && !st.escape) begin
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.out_load) begin
            m_data_reg.out_x           <= px_reg;
            m_data_reg.out_y           <= py_reg;
            m_data_reg.iteration_count <= iter_reg;
            m_data_reg.inside_set      <= (iter_reg == limit_reg);
        end
    end

    assign m_data = m_data_reg;

endmodule

// ----- rtl/mbe_ctrl.sv -----
// Controller state machine: sequences mapping, division, iteration and result hand-off.
module mbe_ctrl #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  mbe_pkg::dp_status_t st,
    output mbe_pkg::ctrl_cmd_t  cmd
);
    import mbe_pkg::*;

    localparam int QB    = FRAC_BITS + 5;
    localparam int CNT_W = $clog2(QB);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_DLOAD;
            ST_DLOAD: begin
                state_next   = ST_DIV;
                div_cnt_next = CNT_W'(QB - 1);
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_MAP;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_MAP:   state_next = st.limit_zero ? ST_FIN : ST_START;
            ST_START: state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_UPD;
            ST_UPD:   state_next = (st.escape || st.last) ? ST_FIN : ST_MUL1;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_PREP:  cmd.prep     = 1'b1;
            ST_DLOAD: cmd.div_load = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_MAP:   cmd.map_done = 1'b1;
            ST_START: begin
                cmd.update = 1'b1;
                cmd.first  = 1'b1;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                cmd.check  = 1'b1;
            end
            ST_FIN:   cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && (st.escape || st.last)) |=> (state_reg == ST_FIN))
        else $error("iteration did not stop on escape or limit");

    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_cnt_reg == '0) |=> (state_reg == ST_MAP))
        else $error("division did not end after its last step");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.update || cmd.div_step || cmd.map_done))
        else $error("datapath advanced while idle");

endmodule

// ----- rtl/mandelbrot_escape_time_top.sv -----
// Top level of the escape-time evaluator: controller, datapath and configuration port.
//
//  channel  direction  handshake             payload
//  s_       in         s_valid / s_ready     in_t  {pixel_x, pixel_y}
//  m_       out        m_valid / m_ready     out_t {out_x, out_y, iteration_count, inside_set}
//  cfg_     in         cfg_valid / cfg_ready cfg_index (register number), cfg_data
//
// One pixel at a time; its duration is set by the one-bit-per-cycle coordinate dividers and
// the two-stage multipliers in the z loop, which runs once per escape check (none at a zero limit).
// Synchronous active-low reset restores the register defaults and empties the result slot.
// A finished result waits in the output register; the next pixel is taken meanwhile and
// only its own completion stalls on m_ready. Configuration transfers are always taken.
module mandelbrot_escape_time_top #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mbe_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mbe_pkg::out_t                  m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    mbe_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mbe_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .st        (st),
        .m_data    (m_data)
    );

endmodule
